### rtl/rhc_pkg.sv
// ---------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants of the rainbow hue cycle colour generator.
// ---------------------------------------------------------------------------
package rhc_pkg;

    localparam int TIME_BITS      = 32;
    localparam int OFFSET_BITS    = 16;
    localparam int PERIOD_BITS    = 16;
    localparam int SUM_BITS       = TIME_BITS + 1;
    localparam int FRAC_BITS      = 16;
    localparam int SECTOR_BITS    = 3;
    localparam int OUT_BITS       = 8;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET  = 16'd1000;
    localparam int                     CHANNEL_RESET = 255;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PERIOD     = 2'd0,
        CFG_SATURATION = 2'd1,
        CFG_BRIGHTNESS = 2'd2
    } cfg_index_t;

    typedef enum logic [SECTOR_BITS-1:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]   time_ms;
        logic [OFFSET_BITS-1:0] hue_offset;
    } rhc_in_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] red;
        logic [OUT_BITS-1:0] green;
        logic [OUT_BITS-1:0] blue;
    } rhc_out_t;

    typedef struct packed {
        sector_t              sector;
        logic [FRAC_BITS-1:0] frac;
    } rhc_cls_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rhc_qstat_t;

endpackage

### rtl/rhc_front.sv
// ---------------------------------------------------------------------------
// rhc_front
// Hue front end: phase reduction modulo the period and hue division into
// sector and fraction, one quotient bit per pipeline stage.
// ---------------------------------------------------------------------------
module rhc_front
    import rhc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   enable,
    input  logic                   in_valid,
    input  rhc_in_t                in_data,
    input  logic [PERIOD_BITS-1:0] period,
    output logic                   cls_valid,
    output rhc_cls_t               cls_data
);

    localparam int PHASE_STAGES = SUM_BITS;
    localparam int FRAC_STAGES  = FRAC_BITS;
    localparam int X_BITS       = PERIOD_BITS + SECTOR_BITS;

    logic                   sum_vld_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic                   ph_vld_reg  [PHASE_STAGES];
    logic [SUM_BITS-1:0]    ph_div_reg  [PHASE_STAGES];
    logic [PERIOD_BITS-1:0] ph_rem_reg  [PHASE_STAGES];
    logic                   sc_vld_reg  [SECTOR_BITS];
    logic [X_BITS-1:0]      sc_x_reg    [SECTOR_BITS];
    logic [SECTOR_BITS-1:0] sc_bits_reg [SECTOR_BITS];
    logic                   fr_vld_reg  [FRAC_STAGES];
    logic [PERIOD_BITS-1:0] fr_rem_reg  [FRAC_STAGES];
    logic [FRAC_BITS-1:0]   fr_frac_reg [FRAC_STAGES];
    sector_t                fr_sec_reg  [FRAC_STAGES];

    // 33-bit time plus offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_vld_reg <= 1'b0;
        end
        else if (enable)
        begin
            sum_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            sum_reg <= SUM_BITS'(in_data.time_ms) + SUM_BITS'(in_data.hue_offset);
        end
    end

    // phase = sum mod period
    for (genvar k = 0; k < PHASE_STAGES; k++)
    begin : g_phase
        logic                   vld_in;
        logic [SUM_BITS-1:0]    div_in;
        logic [PERIOD_BITS-1:0] rem_in;
        logic [PERIOD_BITS:0]   trial;
        logic [PERIOD_BITS:0]   diff;
        logic                   ge;
        logic [PERIOD_BITS-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign vld_in = sum_vld_reg;
            assign div_in = sum_reg;
            assign rem_in = '0;
        end
        else
        begin : g_later
            assign vld_in = ph_vld_reg[k-1];
            assign div_in = ph_div_reg[k-1];
            assign rem_in = ph_rem_reg[k-1];
        end

        assign trial    = {rem_in, div_in[SUM_BITS-1]};
        assign diff     = trial - {1'b0, period};
        assign ge       = trial >= {1'b0, period};
        assign rem_next = ge ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ph_vld_reg[k] <= 1'b0;
            end
            else if (enable)
            begin
                ph_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (enable)
            begin
                ph_div_reg[k] <= {div_in[SUM_BITS-2:0], 1'b0};
                ph_rem_reg[k] <= rem_next;
            end
        end
    end

    // sector = floor(6 * phase / period)
    for (genvar j = 0; j < SECTOR_BITS; j++)
    begin : g_sector
        logic                   vld_in;
        logic [X_BITS-1:0]      x_in;
        logic [SECTOR_BITS-1:0] bits_in;
        logic [X_BITS-1:0]      per_w;
        logic                   ge;

        if (j == 0)
        begin : g_first
            assign vld_in  = ph_vld_reg[PHASE_STAGES-1];
            assign x_in    = X_BITS'({ph_rem_reg[PHASE_STAGES-1], 2'b00})
                           + X_BITS'({ph_rem_reg[PHASE_STAGES-1], 1'b0});
            assign bits_in = '0;
        end
        else
        begin : g_later
            assign vld_in  = sc_vld_reg[j-1];
            assign x_in    = sc_x_reg[j-1];
            assign bits_in = sc_bits_reg[j-1];
        end

        assign per_w = {{SECTOR_BITS{1'b0}}, period} << (SECTOR_BITS - 1 - j);
        assign ge    = x_in >= per_w;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sc_vld_reg[j] <= 1'b0;
            end
            else if (enable)
            begin
                sc_vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (enable)
            begin
                sc_x_reg[j]    <= ge ? (x_in - per_w) : x_in;
                sc_bits_reg[j] <= {bits_in[SECTOR_BITS-2:0], ge};
            end
        end
    end

    // Q0.16 fraction of the sector
    for (genvar j = 0; j < FRAC_STAGES; j++)
    begin : g_frac
        logic                   vld_in;
        logic [PERIOD_BITS-1:0] rem_in;
        logic [FRAC_BITS-1:0]   frac_in;
        sector_t                sec_in;
        logic [PERIOD_BITS:0]   trial;
        logic [PERIOD_BITS:0]   diff;
        logic                   ge;

        if (j == 0)
        begin : g_first
            assign vld_in  = sc_vld_reg[SECTOR_BITS-1];
            assign rem_in  = sc_x_reg[SECTOR_BITS-1][PERIOD_BITS-1:0];
            assign frac_in = '0;
            assign sec_in  = sector_t'(sc_bits_reg[SECTOR_BITS-1]);
        end
        else
        begin : g_later
            assign vld_in  = fr_vld_reg[j-1];
            assign rem_in  = fr_rem_reg[j-1];
            assign frac_in = fr_frac_reg[j-1];
            assign sec_in  = fr_sec_reg[j-1];
        end

        assign trial = {rem_in, 1'b0};
        assign diff  = trial - {1'b0, period};
        assign ge    = trial >= {1'b0, period};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fr_vld_reg[j] <= 1'b0;
            end
            else if (enable)
            begin
                fr_vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (enable)
            begin
                fr_rem_reg[j]  <= ge ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
                fr_frac_reg[j] <= {frac_in[FRAC_BITS-2:0], ge};
                fr_sec_reg[j]  <= sec_in;
            end
        end
    end

    assign cls_valid       = fr_vld_reg[FRAC_STAGES-1];
    assign cls_data.sector = fr_sec_reg[FRAC_STAGES-1];
    assign cls_data.frac   = fr_frac_reg[FRAC_STAGES-1];

    a_phase_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        ph_vld_reg[PHASE_STAGES-1] |-> (ph_rem_reg[PHASE_STAGES-1] < period))
        else $error("phase remainder not below period");

    a_sector_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        sc_vld_reg[SECTOR_BITS-1] |->
            (sc_x_reg[SECTOR_BITS-1] < {{SECTOR_BITS{1'b0}}, period}))
        else $error("sector remainder not below period");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (!enable && cls_valid) |=> (cls_valid && $stable(cls_data)))
        else $error("front word changed while stalled");

endmodule

### rtl/rhc_queue.sv
// ---------------------------------------------------------------------------
// rhc_queue
// Short queue of classified words between the hue front end and the
// colour back end.
// ---------------------------------------------------------------------------
module rhc_queue
    import rhc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  rhc_cls_t   push_data,
    input  logic       pop,
    output rhc_cls_t   pop_data,
    output rhc_qstat_t status
);

    rhc_cls_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;
    logic [QUEUE_PTR_BITS:0]   count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign status.full  = count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from empty queue");

endmodule

### rtl/rhc_back.sv
// ---------------------------------------------------------------------------
// rhc_back
// Colour back end: forms the p, q and t levels from saturation, brightness
// and hue fraction, routes them by sector and holds the output word.
// ---------------------------------------------------------------------------
module rhc_back
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CHANNEL_BITS-1:0] saturation,
    input  logic [CHANNEL_BITS-1:0] brightness,
    input  logic                    cls_valid,
    input  rhc_cls_t                cls_data,
    output logic                    cls_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output rhc_out_t                out_data
);

    localparam int CB       = CHANNEL_BITS;
    localparam int BIG_BITS = CB + FRAC_BITS;
    localparam int PROD_BITS = 2 * CB;

    localparam logic [CB-1:0]       CHAN_MAX = '1;
    localparam logic [BIG_BITS-1:0] BIG      = {CHAN_MAX, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS:0]  FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    function automatic logic [CB-1:0] div_chan_max(input logic [PROD_BITS-1:0] n);
        logic [PROD_BITS:0] acc;
        acc = {1'b0, n} + (PROD_BITS+1)'(n >> CB) + 1'b1;
        return acc[PROD_BITS-1:CB];
    endfunction

    function automatic logic [OUT_BITS-1:0] to_out(input logic [CB-1:0] x);
        logic [CB+OUT_BITS-1:0] wide;
        wide = {{OUT_BITS{1'b0}}, x};
        return wide[OUT_BITS-1:0];
    endfunction

    logic                   adv;

    logic                   s1_vld_reg;
    sector_t                s1_sec_reg;
    logic [BIG_BITS-1:0]    s1_sf_reg;
    logic [BIG_BITS:0]      s1_sg_reg;
    logic [PROD_BITS-1:0]   s1_pn_reg;

    logic                   s2_vld_reg;
    sector_t                s2_sec_reg;
    logic [BIG_BITS-1:0]    s2_uq_reg;
    logic [BIG_BITS-1:0]    s2_ut_reg;
    logic [PROD_BITS-1:0]   s2_pn_reg;
    logic [BIG_BITS:0]      s2_ut_next;

    logic                   s3_vld_reg;
    sector_t                s3_sec_reg;
    logic [PROD_BITS-1:0]   s3_nq_reg;
    logic [PROD_BITS-1:0]   s3_nt_reg;
    logic [PROD_BITS-1:0]   s3_pn_reg;
    logic [PROD_BITS+FRAC_BITS-1:0] s3_nq_next;
    logic [PROD_BITS+FRAC_BITS-1:0] s3_nt_next;

    logic                   s4_vld_reg;
    sector_t                s4_sec_reg;
    logic [CB-1:0]          s4_lp_reg;
    logic [CB-1:0]          s4_lq_reg;
    logic [CB-1:0]          s4_lt_reg;

    logic                   out_vld_reg;
    rhc_out_t               out_reg;
    rhc_out_t               out_next;

    assign adv     = !out_vld_reg || out_ready;
    assign cls_pop = adv && cls_valid;

    assign s2_ut_next = {1'b0, BIG} - s1_sg_reg;
    assign s3_nq_next = (PROD_BITS+FRAC_BITS)'(brightness)
                      * (PROD_BITS+FRAC_BITS)'(s2_uq_reg);
    assign s3_nt_next = (PROD_BITS+FRAC_BITS)'(brightness)
                      * (PROD_BITS+FRAC_BITS)'(s2_ut_reg);

    always_comb
    begin
        logic [CB-1:0] lv;
        lv = brightness;
        unique case (s4_sec_reg)
            SEC_RED_YEL: out_next = '{red: to_out(lv),        green: to_out(s4_lt_reg),
                                      blue: to_out(s4_lp_reg)};
            SEC_YEL_GRN: out_next = '{red: to_out(s4_lq_reg), green: to_out(lv),
                                      blue: to_out(s4_lp_reg)};
            SEC_GRN_CYN: out_next = '{red: to_out(s4_lp_reg), green: to_out(lv),
                                      blue: to_out(s4_lt_reg)};
            SEC_CYN_BLU: out_next = '{red: to_out(s4_lp_reg), green: to_out(s4_lq_reg),
                                      blue: to_out(lv)};
            SEC_BLU_MAG: out_next = '{red: to_out(s4_lt_reg), green: to_out(s4_lp_reg),
                                      blue: to_out(lv)};
            SEC_MAG_RED: out_next = '{red: to_out(lv),        green: to_out(s4_lp_reg),
                                      blue: to_out(s4_lq_reg)};
            default:     out_next = '{red: to_out(lv),        green: to_out(s4_lp_reg),
                                      blue: to_out(s4_lq_reg)};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= cls_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            out_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // products
            s1_sec_reg <= cls_data.sector;
            s1_sf_reg  <= BIG_BITS'(saturation) * BIG_BITS'(cls_data.frac);
            s1_sg_reg  <= (BIG_BITS+1)'(saturation)
                        * (BIG_BITS+1)'(FRAC_ONE - {1'b0, cls_data.frac});
            s1_pn_reg  <= PROD_BITS'(brightness) * PROD_BITS'(CHAN_MAX - saturation);
            // complements
            s2_sec_reg <= s1_sec_reg;
            s2_uq_reg  <= BIG - s1_sf_reg;
            s2_ut_reg  <= s2_ut_next[BIG_BITS-1:0];
            s2_pn_reg  <= s1_pn_reg;
            // scale by brightness, drop the fraction
            s3_sec_reg <= s2_sec_reg;
            s3_nq_reg  <= s3_nq_next[PROD_BITS+FRAC_BITS-1:FRAC_BITS];
            s3_nt_reg  <= s3_nt_next[PROD_BITS+FRAC_BITS-1:FRAC_BITS];
            s3_pn_reg  <= s2_pn_reg;
            // divide by full scale
            s4_sec_reg <= s3_sec_reg;
            s4_lp_reg  <= div_chan_max(s3_pn_reg);
            s4_lq_reg  <= div_chan_max(s3_nq_reg);
            s4_lt_reg  <= div_chan_max(s3_nt_reg);
            out_reg    <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    a_levels_below_value: assert property (@(posedge clk) disable iff (!rst_n)
        s4_vld_reg |-> (s4_lp_reg <= brightness && s4_lq_reg <= brightness
                        && s4_lt_reg <= brightness))
        else $error("colour level above brightness");

    a_no_pop_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cls_pop)
        else $error("queue popped while output stalled");

endmodule

### rtl/rainbow_hue_cycle_rgb.sv
// throughput: one word per cycle while the queue is not full and the
//   output is not stalled
// pipeline: one quotient bit per front-end stage, 33 stages of phase
//   reduction and 19 of hue division, then one queue and 5 colour stages
// reset: period 1000, saturation and brightness full scale, pipelines and
//   queue empty
// ---------------------------------------------------------------------------
// rainbow_hue_cycle_rgb
// Time driven rainbow colour generator: hue from time, offset and period,
// converted from HSV to RGB with fixed saturation and brightness.
// ---------------------------------------------------------------------------
module rainbow_hue_cycle_rgb
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  rhc_in_t                   in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rhc_out_t                  out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam logic [CHANNEL_BITS-1:0] CHAN_RESET = CHANNEL_BITS'(CHANNEL_RESET);

    logic [PERIOD_BITS-1:0]  period_reg;
    logic [CHANNEL_BITS-1:0] sat_reg;
    logic [CHANNEL_BITS-1:0] bri_reg;
    logic [PERIOD_BITS-1:0]  period_eff;

    logic       front_en;
    logic       cls_valid;
    rhc_cls_t   cls_data;
    rhc_cls_t   q_data;
    logic       q_pop;
    rhc_qstat_t q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            sat_reg    <= CHAN_RESET;
            bri_reg    <= CHAN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PERIOD:     period_reg <= cfg_data[PERIOD_BITS-1:0];
                CFG_SATURATION: sat_reg    <= cfg_data[CHANNEL_BITS-1:0];
                CFG_BRIGHTNESS: bri_reg    <= cfg_data[CHANNEL_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // zero period acts as one
    assign period_eff = (period_reg == '0) ? PERIOD_BITS'(1) : period_reg;

    assign front_en = !q_stat.full;
    assign in_ready = front_en;

    rhc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (front_en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .period    (period_eff),
        .cls_valid (cls_valid),
        .cls_data  (cls_data)
    );

    rhc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cls_valid && front_en),
        .push_data (cls_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .status    (q_stat)
    );

    rhc_back #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .saturation (sat_reg),
        .brightness (bri_reg),
        .cls_valid  (!q_stat.empty),
        .cls_data   (q_data),
        .cls_pop    (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

### verif/rainbow_hue_cycle_rgb_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rainbow_hue_cycle_rgb_test
// Self-checking bench for the rainbow hue cycle colour generator. Directed
// words cover sector edges, the 33-bit sum wrap, zero period, grey and
// masked register bits; random words then run under several register
// settings with sender gaps, receiver stalls and one long output hold-off.
// Every colour word is checked against an in-bench HSV to RGB predictor.
// ---------------------------------------------------------------------------
module rainbow_hue_cycle_rgb_test;
    import rhc_pkg::*;

    localparam int CHANNEL_BITS = 8;
    localparam longint unsigned CHAN_MAX = (64'd1 << CHANNEL_BITS) - 64'd1;
    localparam longint unsigned FRAC_ONE = 64'd1 << FRAC_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 70;
    localparam int MAX_REPORTS = 100;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    rhc_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    rhc_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // register copies seen by the predictor
    logic [PERIOD_BITS-1:0] cur_period = PERIOD_RESET;
    logic [CFG_DATA_BITS-1:0] cur_sat = CFG_DATA_BITS'(CHANNEL_RESET & CHAN_MAX);
    logic [CFG_DATA_BITS-1:0] cur_bri = CFG_DATA_BITS'(CHANNEL_RESET & CHAN_MAX);

    rhc_in_t word_backlog[$];
    rhc_out_t colour_due[$];
    rhc_out_t colour_want;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_left = 0;
    int mismatches = 0;
    int cycle_count = 0;

    rainbow_hue_cycle_rgb #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic rhc_out_t hue_to_colour(input rhc_in_t w);
        longint unsigned per, total, phase, h6, f, s, b, big;
        longint unsigned lv, lp, lq, lt;
        sector_t sec;
        rhc_out_t c;
        per = (cur_period == '0) ? 64'd1 : 64'(cur_period);
        total = 64'(w.time_ms) + 64'(w.hue_offset);
        phase = total % per;
        h6 = (phase * 64'd6 * FRAC_ONE) / per;
        sec = sector_t'(h6[FRAC_BITS +: SECTOR_BITS]);
        f = h6 & (FRAC_ONE - 64'd1);
        s = 64'(cur_sat);
        b = 64'(cur_bri);
        big = CHAN_MAX * FRAC_ONE;
        lv = b;
        lp = (b * (CHAN_MAX - s)) / CHAN_MAX;
        lq = (b * (big - s * f)) / big;
        lt = (b * (big - s * (FRAC_ONE - f))) / big;
        case (sec)
            SEC_RED_YEL: c = {lv[7:0], lt[7:0], lp[7:0]};
            SEC_YEL_GRN: c = {lq[7:0], lv[7:0], lp[7:0]};
            SEC_GRN_CYN: c = {lp[7:0], lv[7:0], lt[7:0]};
            SEC_CYN_BLU: c = {lp[7:0], lq[7:0], lv[7:0]};
            SEC_BLU_MAG: c = {lt[7:0], lp[7:0], lv[7:0]};
            default:     c = {lv[7:0], lp[7:0], lq[7:0]};
        endcase
        return c;
    endfunction

    function automatic rhc_in_t random_word(input logic [PERIOD_BITS-1:0] per);
        rhc_in_t w;
        int pick;
        pick = $urandom_range(99);
        w.time_ms = $urandom;
        w.hue_offset = OFFSET_BITS'($urandom_range(65535));
        if (pick < 10)
        begin
            w.time_ms = 32'hFFFF_FFFF - $urandom_range(70000);
        end
        else if (pick < 22)
        begin
            w.time_ms = $urandom_range(3 * int'(per) + 2);
        end
        else if (pick < 26)
        begin
            w.time_ms = '1;
            w.hue_offset = '1;
        end
        else if (pick < 30)
        begin
            w.time_ms = '0;
            w.hue_offset = '0;
        end
        return w;
    endfunction

    function automatic void report_field(input string name, input logic [OUT_BITS-1:0] want,
                                         input logic [OUT_BITS-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
            end
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                colour_due = {colour_due, hue_to_colour(in_data)};
            end
            if (!(in_valid && !in_ready))
            begin
                if (word_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= word_backlog.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (colour_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t unexpected colour word: expected none actual %h",
                                 $time, out_data);
                    end
                end
                else
                begin
                    colour_want = colour_due.pop_front();
                    report_field("red", colour_want.red, out_data.red);
                    report_field("green", colour_want.green, out_data.green);
                    report_field("blue", colour_want.blue, out_data.blue);
                end
            end
            out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long output hold-off
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PERIOD:     cur_period = value;
            CFG_SATURATION: cur_sat = CFG_DATA_BITS'(value & CHAN_MAX);
            CFG_BRIGHTNESS: cur_bri = CFG_DATA_BITS'(value & CHAN_MAX);
            default:        ;
        endcase
    endtask

    task automatic set_colour(input logic [PERIOD_BITS-1:0] per,
                              input logic [CFG_DATA_BITS-1:0] sat,
                              input logic [CFG_DATA_BITS-1:0] bri);
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_SATURATION, sat);
        write_reg(CFG_BRIGHTNESS, bri);
    endtask

    // sampled between edges so the driver's updates have settled
    task automatic drain(input int settle);
        while (!(word_backlog.size() == 0 && !in_valid && colour_due.size() == 0))
        begin
            @(negedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic queue_word(input logic [TIME_BITS-1:0] t, input logic [OFFSET_BITS-1:0] o);
        rhc_in_t w;
        w.time_ms = t;
        w.hue_offset = o;
        word_backlog = {word_backlog, w};
    endtask

    task automatic run_random(input logic [PERIOD_BITS-1:0] per,
                              input logic [CFG_DATA_BITS-1:0] sat,
                              input logic [CFG_DATA_BITS-1:0] bri,
                              input int idle_pct, input int stall_pct,
                              input int hold, input int count);
        drain(4);
        set_colour(per, sat, bri);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        @(posedge clk);
        if (hold != 0)
        begin
            stall_left <= hold;
        end
        repeat (count) word_backlog = {word_backlog, random_word(per)};
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: sector edges, 33-bit sum wrap
        queue_word(32'd0, 16'd0);
        queue_word(32'hFFFF_FFFF, 16'hFFFF);
        queue_word(32'd999, 16'd0);
        queue_word(32'd1000, 16'd0);
        queue_word(32'd0, 16'd999);
        queue_word(32'd166, 16'd0);
        queue_word(32'd167, 16'd0);
        queue_word(32'd333, 16'd0);
        queue_word(32'd500, 16'd0);
        queue_word(32'd667, 16'd0);
        queue_word(32'd833, 16'd0);
        drain(4);

        // period of six: one word per sector, fraction zero
        set_colour(16'd6, 16'd255, 16'd255);
        for (int i = 0; i < 6; i++)
        begin
            queue_word(TIME_BITS'(i), 16'd0);
        end
        queue_word(32'hFFFF_FFFF, 16'd1);
        drain(4);

        // zero period, grey through masked saturation, masked brightness
        set_colour(16'd0, 16'hFF00, 16'h0180);
        queue_word(32'd12345, 16'd77);
        drain(4);
        write_reg(CFG_SPARE, 16'hA5A5);

        set_colour(16'hFFFF, 16'h00FF, 16'hFFFF);
        queue_word(32'd65534, 16'd0);
        queue_word(32'd0, 16'hFFFF);

        run_random(16'd1000, 16'd255, 16'd255, 0, 0, 0, 200);
        run_random(16'hFFFF, 16'd255, 16'd255, 55, 0, 0, 200);
        run_random(16'd6, 16'd200, 16'd100, 0, 55, 0, 200);
        run_random(PERIOD_BITS'($urandom_range(65535)),
                   CFG_DATA_BITS'($urandom_range(65535)),
                   CFG_DATA_BITS'($urandom_range(65535)),
                   12, 12, 0, 200);
        run_random(16'd3000, 16'd170, 16'd230, 0, 0, 400, 200);
        run_random(16'd1, 16'd255, 16'd0, 55, 0, 0, 100);
        run_random(16'd0, 16'hFFFF, 16'h00C3, 0, 55, 0, 100);
        run_random(16'hFFFF, 16'd0, 16'd0, 12, 12, 0, 100);
        for (int i = 0; i < 3; i++)
        begin
            run_random(PERIOD_BITS'($urandom_range(65535)),
                       CFG_DATA_BITS'($urandom_range(65535)),
                       CFG_DATA_BITS'($urandom_range(65535)),
                       (i == 1) ? 55 : 12, (i == 2) ? 55 : 12, 0, 100);
        end

        drain(SETTLE_CYCLES);
        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
rtl/rhc_pkg.sv
rtl/rhc_front.sv
rtl/rhc_queue.sv
rtl/rhc_back.sv
rtl/rainbow_hue_cycle_rgb.sv
verif/rainbow_hue_cycle_rgb_test.sv
